### rtl/core/mka_pkg.sv
// Package for the mouse keys accelerator: operation and register codes,
// reset values, datapath widths and the microcode ROM of the sequencer.
// No dependencies.
`default_nettype none

package mka_pkg;

    // ---- datapath widths ----
    localparam int FullW   = 14;              // move_delta * max_speed
    localparam int ProdW   = FullW + 8;       // full * repeat_count
    localparam int DivCntW = $clog2(ProdW + 1);
    localparam logic [DivCntW-1:0] DIV_STEPS = DivCntW'(ProdW);

    // ---- operations carried on s_tuser ----
    localparam logic [2:0] OP_BTN_PRESS   = 3'd0;
    localparam logic [2:0] OP_BTN_RELEASE = 3'd1;
    localparam logic [2:0] OP_CUR_PRESS   = 3'd2;
    localparam logic [2:0] OP_CUR_RELEASE = 3'd3;
    localparam logic [2:0] OP_TICK        = 3'd4;
    localparam logic [2:0] OP_SEND        = 3'd5;

    // ---- direction mask bits ----
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    // ---- configuration register indexes ----
    localparam logic [2:0] CFG_MOVE_DELTA      = 3'd0;
    localparam logic [2:0] CFG_MAX_SPEED       = 3'd1;
    localparam logic [2:0] CFG_RAMP_REPEATS    = 3'd2;
    localparam logic [2:0] CFG_MOVE_CAP        = 3'd3;
    localparam logic [2:0] CFG_REPEAT_INTERVAL = 3'd4;
    localparam logic [2:0] CFG_INITIAL_DELAY   = 3'd5;
    localparam logic [2:0] CFG_REPEAT_CEILING  = 3'd6;

    // ---- configuration reset values ----
    localparam logic [6:0]  RST_MOVE_DELTA      = 7'd5;
    localparam logic [6:0]  RST_MAX_SPEED       = 7'd10;
    localparam logic [7:0]  RST_RAMP_REPEATS    = 8'd30;
    localparam logic [14:0] RST_MOVE_CAP        = 15'd127;
    localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd20;
    localparam logic [15:0] RST_INITIAL_DELAY   = 16'd300;
    localparam logic [7:0]  RST_REPEAT_CEILING  = 8'd255;

    // ---- diagonal scale factor, over 256 ----
    localparam logic [7:0] DIAG_FACTOR = 8'd181;

    // ---- sequencer ----
    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_BTN     = 4'd1;
    localparam step_t STEP_CREL    = 4'd2;
    localparam step_t STEP_TICK    = 4'd3;
    localparam step_t STEP_MULFULL = 4'd4;
    localparam step_t STEP_MULR    = 4'd5;
    localparam step_t STEP_DIV     = 4'd6;
    localparam step_t STEP_UNIT    = 4'd7;
    localparam step_t STEP_APPLY   = 4'd8;
    localparam step_t STEP_DIAG    = 4'd9;
    localparam step_t STEP_SEND    = 4'd10;
    localparam step_t STEP_WAIT    = 4'd11;
    localparam step_t STEP_EMIT    = 4'd12;

    typedef enum logic [3:0] {
        ACT_NOP     = 4'd0,
        ACT_ACCEPT  = 4'd1,
        ACT_BTN     = 4'd2,
        ACT_CREL    = 4'd3,
        ACT_TICK    = 4'd4,
        ACT_MULFULL = 4'd5,
        ACT_MULR    = 4'd6,
        ACT_DIV     = 4'd7,
        ACT_UNIT    = 4'd8,
        ACT_APPLY   = 4'd9,
        ACT_DIAG    = 4'd10,
        ACT_EMIT    = 4'd11
    } action_t;

    typedef enum logic [3:0] {
        CND_NEXT      = 4'd0,
        CND_ALWAYS    = 4'd1,
        CND_DISPATCH  = 4'd2,
        CND_NO_REPEAT = 4'd3,
        CND_NO_DIV    = 4'd4,
        CND_DIV_MORE  = 4'd5,
        CND_IS_PRESS  = 4'd6,
        CND_NO_CHANGE = 4'd7,
        CND_OUT_BUSY  = 4'd8
    } cond_t;

    typedef struct packed {
        action_t act;
        cond_t   cnd;
        step_t   target;
    } uword_t;

    function automatic uword_t ucode_rom(step_t pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE:    w = '{ACT_ACCEPT,  CND_DISPATCH,  STEP_IDLE};
            STEP_BTN:     w = '{ACT_BTN,     CND_ALWAYS,    STEP_IDLE};
            STEP_CREL:    w = '{ACT_CREL,    CND_ALWAYS,    STEP_IDLE};
            STEP_TICK:    w = '{ACT_TICK,    CND_NO_REPEAT, STEP_IDLE};
            STEP_MULFULL: w = '{ACT_MULFULL, CND_NEXT,      STEP_IDLE};
            STEP_MULR:    w = '{ACT_MULR,    CND_NO_DIV,    STEP_UNIT};
            STEP_DIV:     w = '{ACT_DIV,     CND_DIV_MORE,  STEP_DIV};
            STEP_UNIT:    w = '{ACT_UNIT,    CND_NEXT,      STEP_IDLE};
            STEP_APPLY:   w = '{ACT_APPLY,   CND_IS_PRESS,  STEP_IDLE};
            STEP_DIAG:    w = '{ACT_DIAG,    CND_ALWAYS,    STEP_IDLE};
            STEP_SEND:    w = '{ACT_NOP,     CND_NO_CHANGE, STEP_IDLE};
            STEP_WAIT:    w = '{ACT_NOP,     CND_OUT_BUSY,  STEP_WAIT};
            STEP_EMIT:    w = '{ACT_EMIT,    CND_ALWAYS,    STEP_IDLE};
            default:      w = '{ACT_NOP,     CND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch(logic [2:0] op);
        step_t s;
        unique case (op)
            OP_BTN_PRESS,
            OP_BTN_RELEASE: s = STEP_BTN;
            OP_CUR_PRESS:   s = STEP_MULFULL;
            OP_CUR_RELEASE: s = STEP_CREL;
            OP_TICK:        s = STEP_TICK;
            OP_SEND:        s = STEP_SEND;
            default:        s = STEP_IDLE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mouse_keys_accelerator.sv
// Mouse keys accelerator top level: microcoded sequencer with step counter,
// separate multipliers and restoring divider for the speed ramp, output register.
// Depends on mka_pkg.
//
//  channel  | port group                  | contents
//  ---------+-----------------------------+------------------------------------
//  input    | s_tvalid/s_tready/s_tdata   | key, tick or send event word
//  result   | m_tvalid/m_tready/m_tdata   | mouse report word
//  config   | cfg_wr_en/cfg_addr/cfg_wdata| register write, no read-back
//
// Buttons, cursor release and an idle tick return to IDLE from their own step; send does too
// when nothing changed, else it passes WAIT and EMIT. Cursor press and a repeating tick run
// the speed ramp; its 22-step divider loop is skipped when no division is due.
// A report waits in the output register; a later report waits at the WAIT step.
// Reset is synchronous, active low; it clears state and control and loads configuration defaults, not the datapath.
`default_nettype none

module mouse_keys_accelerator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: code[3:0], time_ms[35:4], zero pad [39:36]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // s_tuser: operation[2:0]
    input  wire logic [2:0]  s_tuser,
    // m_tdata: button_bits[7:0], move_x[23:8], move_y[39:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int FullW = mka_pkg::FullW;
    localparam int ProdW = mka_pkg::ProdW;
    localparam int CntW  = mka_pkg::DivCntW;

    // configuration
    logic [6:0]  move_delta_reg,  move_delta_next;
    logic [6:0]  max_speed_reg,   max_speed_next;
    logic [7:0]  ramp_reg,        ramp_next;
    logic [14:0] cap_reg,         cap_next;
    logic [15:0] interval_reg,    interval_next;
    logic [15:0] delay_reg,       delay_next;
    logic [7:0]  ceiling_reg,     ceiling_next;

    // architectural state
    logic [7:0]         cur_buttons_reg,  cur_buttons_next;
    logic signed [15:0] cur_x_reg,        cur_x_next;
    logic signed [15:0] cur_y_reg,        cur_y_next;
    logic [7:0]         sent_buttons_reg, sent_buttons_next;
    logic signed [15:0] sent_x_reg,       sent_x_next;
    logic signed [15:0] sent_y_reg,       sent_y_next;
    logic [3:0]         held_reg,         held_next;
    logic [31:0]        last_ms_reg,      last_ms_next;
    logic [7:0]         rcount_reg,       rcount_next;

    // sequencer and datapath
    mka_pkg::step_t     pc_reg, pc_next;
    mka_pkg::uword_t    uw;
    logic [2:0]         op_reg,   op_next;
    logic [3:0]         code_reg, code_next;
    logic [31:0]        time_reg, time_next;
    logic [FullW-1:0]   full_reg, full_next;
    logic [ProdW-1:0]   quo_reg,  quo_next;
    logic [7:0]         rem_reg,  rem_next;
    logic [CntW-1:0]    cnt_reg,  cnt_next;
    logic [14:0]        unit_reg, unit_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg,  m_tdata_next;

    logic        take;
    logic [31:0] elapsed;
    logic [15:0] limit;
    logic        tick_go;
    logic        no_div;
    logic        no_change;
    logic        out_busy;
    logic [8:0]  div_shift;
    logic        div_ge;
    logic [8:0]  div_diff;
    logic [FullW-1:0] raw_unit;
    logic [15:0] pos_unit;
    logic [15:0] neg_unit;
    logic [3:0]  apply_dirs;
    logic [3:0]  held_rel;

    function automatic logic signed [15:0] diag_scale(logic signed [15:0] v);
        logic        neg;
        logic [15:0] mag;
        logic [22:0] prod;
        logic [14:0] m;
        neg  = v[15];
        mag  = neg ? 16'(-v) : 16'(v);
        prod = {8'b0, mag[14:0]} * {15'b0, mka_pkg::DIAG_FACTOR};
        m    = prod[22:8];
        if (m == 15'd0) begin
            m = 15'd1;
        end
        return neg ? 16'(-{1'b0, m}) : {1'b0, m};
    endfunction

    assign uw       = mka_pkg::ucode_rom(pc_reg);
    assign s_tready = (pc_reg == mka_pkg::STEP_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign elapsed   = time_reg - last_ms_reg;
    assign limit     = (rcount_reg != 8'd0) ? interval_reg : delay_reg;
    assign tick_go   = (held_reg != 4'd0) && (elapsed > {16'b0, limit});
    assign no_div    = (rcount_reg == 8'd0) || (rcount_reg >= ramp_reg);
    assign no_change = (cur_buttons_reg == sent_buttons_reg) &&
                       (cur_x_reg == sent_x_reg) && (cur_y_reg == sent_y_reg);
    assign out_busy  = m_tvalid_reg && !m_tready;

    assign div_shift = {rem_reg, quo_reg[ProdW-1]};
    assign div_ge    = (div_shift >= {1'b0, ramp_reg});
    assign div_diff  = div_shift - {1'b0, ramp_reg};

    assign raw_unit  = (rcount_reg == 8'd0) ? FullW'(move_delta_reg) :
                       (rcount_reg >= ramp_reg) ? full_reg : quo_reg[FullW-1:0];
    assign pos_unit  = {1'b0, unit_reg};
    assign neg_unit  = 16'(-pos_unit);
    assign apply_dirs = (op_reg == mka_pkg::OP_CUR_PRESS) ? code_reg : held_reg;
    assign held_rel  = held_reg & ~code_reg;

    // next step
    always_comb begin
        take = 1'b0;
        unique case (uw.cnd)
            mka_pkg::CND_NEXT:      take = 1'b0;
            mka_pkg::CND_ALWAYS:    take = 1'b1;
            mka_pkg::CND_DISPATCH:  take = 1'b1;
            mka_pkg::CND_NO_REPEAT: take = !tick_go;
            mka_pkg::CND_NO_DIV:    take = no_div;
            mka_pkg::CND_DIV_MORE:  take = (cnt_reg != CntW'(1));
            mka_pkg::CND_IS_PRESS:  take = (op_reg == mka_pkg::OP_CUR_PRESS);
            mka_pkg::CND_NO_CHANGE: take = no_change;
            mka_pkg::CND_OUT_BUSY:  take = out_busy;
            default:                take = 1'b1;
        endcase
        if (uw.cnd == mka_pkg::CND_DISPATCH) begin
            pc_next = s_tvalid ? mka_pkg::dispatch(s_tuser) : mka_pkg::STEP_IDLE;
        end else if (take) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_reg + 4'd1;
        end
    end

    // datapath
    always_comb begin
        move_delta_next   = move_delta_reg;
        max_speed_next    = max_speed_reg;
        ramp_next         = ramp_reg;
        cap_next          = cap_reg;
        interval_next     = interval_reg;
        delay_next        = delay_reg;
        ceiling_next      = ceiling_reg;
        cur_buttons_next  = cur_buttons_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        sent_buttons_next = sent_buttons_reg;
        sent_x_next       = sent_x_reg;
        sent_y_next       = sent_y_reg;
        held_next         = held_reg;
        last_ms_next      = last_ms_reg;
        rcount_next       = rcount_reg;
        op_next           = op_reg;
        code_next         = code_reg;
        time_next         = time_reg;
        full_next         = full_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        unit_next         = unit_reg;
        m_tdata_next      = m_tdata_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                mka_pkg::CFG_MOVE_DELTA:      move_delta_next = cfg_wdata[6:0];
                mka_pkg::CFG_MAX_SPEED:       max_speed_next  = cfg_wdata[6:0];
                mka_pkg::CFG_RAMP_REPEATS:    ramp_next       = cfg_wdata[7:0];
                mka_pkg::CFG_MOVE_CAP:        cap_next        = cfg_wdata[14:0];
                mka_pkg::CFG_REPEAT_INTERVAL: interval_next   = cfg_wdata;
                mka_pkg::CFG_INITIAL_DELAY:   delay_next      = cfg_wdata;
                mka_pkg::CFG_REPEAT_CEILING:  ceiling_next    = cfg_wdata[7:0];
                default: ;
            endcase
        end

        unique case (uw.act)
            mka_pkg::ACT_NOP: ;
            mka_pkg::ACT_ACCEPT: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    code_next = s_tdata[3:0];
                    time_next = s_tdata[35:4];
                end
            end
            mka_pkg::ACT_BTN: begin
                if (!code_reg[3]) begin
                    if (op_reg == mka_pkg::OP_BTN_PRESS) begin
                        cur_buttons_next = cur_buttons_reg | (8'd1 << code_reg[2:0]);
                    end else begin
                        cur_buttons_next = cur_buttons_reg & ~(8'd1 << code_reg[2:0]);
                    end
                end
            end
            mka_pkg::ACT_CREL: begin
                held_next = held_rel;
                if (held_rel != 4'd0) begin
                    last_ms_next = time_reg;
                end else begin
                    rcount_next = 8'd0;
                end
                if (code_reg[mka_pkg::DIR_UP] && cur_y_reg < 0) begin
                    cur_y_next = '0;
                end
                if (code_reg[mka_pkg::DIR_DOWN] && cur_y_reg > 0) begin
                    cur_y_next = '0;
                end
                if (code_reg[mka_pkg::DIR_LEFT] && cur_x_reg < 0) begin
                    cur_x_next = '0;
                end
                if (code_reg[mka_pkg::DIR_RIGHT] && cur_x_reg > 0) begin
                    cur_x_next = '0;
                end
            end
            mka_pkg::ACT_TICK: begin
                if (tick_go) begin
                    if (rcount_reg < ceiling_reg) begin
                        rcount_next = rcount_reg + 8'd1;
                    end
                    last_ms_next = time_reg;
                end
            end
            mka_pkg::ACT_MULFULL: begin
                full_next = {7'b0, move_delta_reg} * {7'b0, max_speed_reg};
            end
            mka_pkg::ACT_MULR: begin
                quo_next = {8'b0, full_reg} * {{(ProdW-8){1'b0}}, rcount_reg};
                rem_next = 8'd0;
                cnt_next = mka_pkg::DIV_STEPS;
            end
            mka_pkg::ACT_DIV: begin
                rem_next = div_ge ? div_diff[7:0] : div_shift[7:0];
                quo_next = {quo_reg[ProdW-2:0], div_ge};
                cnt_next = cnt_reg - CntW'(1);
            end
            mka_pkg::ACT_UNIT: begin
                if ({1'b0, raw_unit} > cap_reg) begin
                    unit_next = cap_reg;
                end else if (raw_unit == '0) begin
                    unit_next = 15'd1;
                end else begin
                    unit_next = {1'b0, raw_unit};
                end
            end
            mka_pkg::ACT_APPLY: begin
                if (apply_dirs[mka_pkg::DIR_DOWN]) begin
                    cur_y_next = pos_unit;
                end else if (apply_dirs[mka_pkg::DIR_UP]) begin
                    cur_y_next = neg_unit;
                end
                if (apply_dirs[mka_pkg::DIR_RIGHT]) begin
                    cur_x_next = pos_unit;
                end else if (apply_dirs[mka_pkg::DIR_LEFT]) begin
                    cur_x_next = neg_unit;
                end
                if (op_reg == mka_pkg::OP_CUR_PRESS) begin
                    held_next    = held_reg | code_reg;
                    last_ms_next = time_reg;
                end
            end
            mka_pkg::ACT_DIAG: begin
                if (cur_x_reg != 0 && cur_y_reg != 0) begin
                    cur_x_next = diag_scale(cur_x_reg);
                    cur_y_next = diag_scale(cur_y_reg);
                end
            end
            mka_pkg::ACT_EMIT: begin
                m_tdata_next      = {cur_y_reg, cur_x_reg, cur_buttons_reg};
                m_tvalid_next     = 1'b1;
                sent_buttons_next = cur_buttons_reg;
                sent_x_next       = cur_x_reg;
                sent_y_next       = cur_y_reg;
                cur_x_next        = '0;
                cur_y_next        = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_delta_reg   <= mka_pkg::RST_MOVE_DELTA;
            max_speed_reg    <= mka_pkg::RST_MAX_SPEED;
            ramp_reg         <= mka_pkg::RST_RAMP_REPEATS;
            cap_reg          <= mka_pkg::RST_MOVE_CAP;
            interval_reg     <= mka_pkg::RST_REPEAT_INTERVAL;
            delay_reg        <= mka_pkg::RST_INITIAL_DELAY;
            ceiling_reg      <= mka_pkg::RST_REPEAT_CEILING;
            cur_buttons_reg  <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            sent_buttons_reg <= '0;
            sent_x_reg       <= '0;
            sent_y_reg       <= '0;
            held_reg         <= '0;
            last_ms_reg      <= '0;
            rcount_reg       <= '0;
            pc_reg           <= mka_pkg::STEP_IDLE;
            m_tvalid_reg     <= 1'b0;
        end else begin
            move_delta_reg   <= move_delta_next;
            max_speed_reg    <= max_speed_next;
            ramp_reg         <= ramp_next;
            cap_reg          <= cap_next;
            interval_reg     <= interval_next;
            delay_reg        <= delay_next;
            ceiling_reg      <= ceiling_next;
            cur_buttons_reg  <= cur_buttons_next;
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            sent_buttons_reg <= sent_buttons_next;
            sent_x_reg       <= sent_x_next;
            sent_y_reg       <= sent_y_next;
            held_reg         <= held_next;
            last_ms_reg      <= last_ms_next;
            rcount_reg       <= rcount_next;
            pc_reg           <= pc_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        code_reg    <= code_next;
        time_reg    <= time_next;
        full_reg    <= full_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        unit_reg    <= unit_next;
        m_tdata_reg <= m_tdata_next;
    end

    // a report leaves the sequencer only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == mka_pkg::STEP_EMIT) |-> !out_busy)
        else $error("report emitted over a waiting word");

    // an emitted report matches the sent copy and clears pending motion
    a_emit_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == mka_pkg::STEP_EMIT) |=>
            (m_tvalid && m_tdata_reg == {sent_y_reg, sent_x_reg, sent_buttons_reg}
             && cur_x_reg == 16'sd0 && cur_y_reg == 16'sd0))
        else $error("report does not match sent state");

    // the divider loop never runs past its last step
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == mka_pkg::STEP_DIV) |-> (cnt_reg != '0))
        else $error("divider step count underflow");

    // the selected step is capped or the floor of one
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == mka_pkg::STEP_APPLY) |-> (unit_reg <= cap_reg || unit_reg == 15'd1))
        else $error("cursor step above cap");

endmodule

`default_nettype wire

### verif/mka_report_checker.sv
// Report checker for mouse_keys_accelerator: follows the event, report and register
// write ports, predicts every mouse report and compares it field by field.
// Depends on mka_pkg.
`default_nettype none

module mka_report_checker
    import mka_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // s_tdata: code[3:0], time_ms[35:4], zero pad [39:36]
    input  wire logic [39:0] s_tdata,
    // s_tuser: operation[2:0]
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: button_bits[7:0], move_x[23:8], move_y[39:24]
    input  wire logic [39:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output int               fail_count,
    output int               reports_pending
);

    typedef struct packed {
        logic signed [15:0] move_y;
        logic signed [15:0] move_x;
        logic [7:0]         buttons;
    } report_t;

    report_t expected_reports[$];

    int mismatches = 0;
    int pending_n  = 0;

    assign fail_count      = mismatches;
    assign reports_pending = pending_n;

    logic [6:0]  base_step;
    logic [6:0]  speed_mult;
    logic [7:0]  ramp_len;
    logic [14:0] step_cap;
    logic [15:0] repeat_gap;
    logic [15:0] first_delay;
    logic [7:0]  count_limit;

    logic [7:0]         btn_now, btn_sent;
    logic signed [15:0] x_now, y_now, x_sent, y_sent;
    logic [3:0]         dirs_held;
    logic [31:0]        last_ms;
    logic [7:0]         repeats;

    function automatic logic signed [15:0] ramp_step();
        logic [31:0] full_step;
        logic [31:0] step_len;
        full_step = 32'(base_step) * 32'(speed_mult);
        if (repeats == 8'd0)
            step_len = 32'(base_step);
        else if (repeats >= ramp_len)
            step_len = full_step;
        else
            step_len = (full_step * 32'(repeats)) / 32'(ramp_len);
        if (step_len > 32'(step_cap))
            step_len = 32'(step_cap);
        else if (step_len == 32'd0)
            step_len = 32'd1;
        return 16'(step_len);
    endfunction

    function automatic logic signed [15:0] diag_shrink(input logic signed [15:0] v);
        int mag;
        mag = v;
        if (mag < 0)
            mag = -mag;
        mag = (mag * int'(DIAG_FACTOR)) / 256;
        if (mag == 0)
            mag = 1;
        return (v < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic steer(input logic [3:0] dirs, input logic signed [15:0] step_len);
        if (dirs[DIR_UP])    y_now = -step_len;
        if (dirs[DIR_DOWN])  y_now = step_len;
        if (dirs[DIR_LEFT])  x_now = -step_len;
        if (dirs[DIR_RIGHT]) x_now = step_len;
    endtask

    task automatic apply_event(input logic [2:0] op, input logic [3:0] code,
                               input logic [31:0] stamp);
        logic [31:0] elapsed;
        logic [31:0] wait_ms;
        case (op)
            OP_BTN_PRESS: begin
                if (!code[3])
                    btn_now[code[2:0]] = 1'b1;
            end
            OP_BTN_RELEASE: begin
                if (!code[3])
                    btn_now[code[2:0]] = 1'b0;
            end
            OP_CUR_PRESS: begin
                steer(code, ramp_step());
                dirs_held = dirs_held | code;
                last_ms = stamp;
            end
            OP_CUR_RELEASE: begin
                dirs_held = dirs_held & ~code;
                if (dirs_held != 4'd0)
                    last_ms = stamp;
                else
                    repeats = 8'd0;
                if (code[DIR_UP] && y_now < 0)    y_now = '0;
                if (code[DIR_DOWN] && y_now > 0)  y_now = '0;
                if (code[DIR_LEFT] && x_now < 0)  x_now = '0;
                if (code[DIR_RIGHT] && x_now > 0) x_now = '0;
            end
            OP_TICK: begin
                elapsed = stamp - last_ms;
                wait_ms = (repeats != 8'd0) ? 32'(repeat_gap) : 32'(first_delay);
                if (dirs_held != 4'd0 && elapsed > wait_ms) begin
                    if (repeats < count_limit)
                        repeats = repeats + 8'd1;
                    steer(dirs_held, ramp_step());
                    if (x_now != 0 && y_now != 0) begin
                        x_now = diag_shrink(x_now);
                        y_now = diag_shrink(y_now);
                    end
                    last_ms = stamp;
                end
            end
            OP_SEND: begin
                if (btn_now != btn_sent || x_now != x_sent || y_now != y_sent) begin
                    expected_reports.push_back('{y_now, x_now, btn_now});
                    btn_sent = btn_now;
                    x_sent = x_now;
                    y_sent = y_now;
                    x_now = '0;
                    y_now = '0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        report_t got;
        report_t want;
        if (!aresetn) begin
            base_step   = RST_MOVE_DELTA;
            speed_mult  = RST_MAX_SPEED;
            ramp_len    = RST_RAMP_REPEATS;
            step_cap    = RST_MOVE_CAP;
            repeat_gap  = RST_REPEAT_INTERVAL;
            first_delay = RST_INITIAL_DELAY;
            count_limit = RST_REPEAT_CEILING;
            btn_now = '0; btn_sent = '0;
            x_now = '0; y_now = '0; x_sent = '0; y_sent = '0;
            dirs_held = '0; last_ms = '0; repeats = '0;
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, got %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.buttons !== want.buttons) begin
                        $display("%0t: button_bits expected %h got %h",
                                 $time, want.buttons, got.buttons);
                        mismatches++;
                    end
                    if (got.move_x !== want.move_x) begin
                        $display("%0t: move_x expected %0d got %0d",
                                 $time, want.move_x, got.move_x);
                        mismatches++;
                    end
                    if (got.move_y !== want.move_y) begin
                        $display("%0t: move_y expected %0d got %0d",
                                 $time, want.move_y, got.move_y);
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MOVE_DELTA:      base_step   = cfg_wdata[6:0];
                    CFG_MAX_SPEED:       speed_mult  = cfg_wdata[6:0];
                    CFG_RAMP_REPEATS:    ramp_len    = cfg_wdata[7:0];
                    CFG_MOVE_CAP:        step_cap    = cfg_wdata[14:0];
                    CFG_REPEAT_INTERVAL: repeat_gap  = cfg_wdata;
                    CFG_INITIAL_DELAY:   first_delay = cfg_wdata;
                    CFG_REPEAT_CEILING:  count_limit = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                apply_event(s_tuser, s_tdata[3:0], s_tdata[35:4]);
        end
        pending_n = expected_reports.size();
    end

endmodule

`default_nettype wire

### verif/tb_mouse_keys_accelerator.sv
// Testbench top for mouse_keys_accelerator: drives key, tick and send words and
// register writes, stalls both sides at random and prints the verdict.
// Depends on mka_pkg, mouse_keys_accelerator and mka_report_checker.
`default_nettype none

module tb_mouse_keys_accelerator;
    import mka_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [3:0] MASK_UP    = 4'(1 << DIR_UP);
    localparam logic [3:0] MASK_DOWN  = 4'(1 << DIR_DOWN);
    localparam logic [3:0] MASK_LEFT  = 4'(1 << DIR_LEFT);
    localparam logic [3:0] MASK_RIGHT = 4'(1 << DIR_RIGHT);
    localparam logic [3:0] MASK_ALL   = 4'hF;

    localparam int RUN_LIMIT      = 400000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_WORDS    = 70;
    localparam int IDLE_PCT       = 21;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;

    int          fail_count;
    int          reports_pending;
    int          cycle_count = 0;
    int          phase_words = 0;
    logic [31:0] now_ms      = '0;
    logic [15:0] gap_ms      = RST_REPEAT_INTERVAL;
    logic [15:0] delay_ms    = RST_INITIAL_DELAY;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    bit          holdoff_req = 1'b0;

    mouse_keys_accelerator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    mka_report_checker report_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .reports_pending (reports_pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("mouse_keys_accelerator verification failed");
        $finish;
    end

    // hold off the report side on request, else stall at random
    initial begin
        forever begin
            @(posedge aclk);
            if (holdoff_req) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_req = 1'b0;
            end
            m_tready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic push_word(input logic [2:0] op, input logic [3:0] code,
                             input logic [31:0] stamp);
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, stamp, code};
        do @(posedge aclk); while (!s_tready);
        phase_words++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [6:0] delta, input logic [6:0] speed,
                                 input logic [7:0] ramp, input logic [14:0] cap,
                                 input logic [15:0] interval, input logic [15:0] delay,
                                 input logic [7:0] ceiling);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(CFG_MOVE_DELTA, 16'(delta));
        write_reg(CFG_MAX_SPEED, 16'(speed));
        write_reg(CFG_RAMP_REPEATS, 16'(ramp));
        write_reg(CFG_MOVE_CAP, 16'(cap));
        write_reg(CFG_REPEAT_INTERVAL, interval);
        write_reg(CFG_INITIAL_DELAY, delay);
        write_reg(CFG_REPEAT_CEILING, 16'(ceiling));
        gap_ms = interval;
        delay_ms = delay;
        phase_words = 0;
    endtask

    task automatic load_random_settings();
        load_settings(7'($urandom_range(1, 127)), 7'($urandom_range(1, 64)),
                      8'($urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 255)),
                      15'($urandom_range(0, 1) ? $urandom_range(1, 300)
                                               : $urandom_range(1, 32767)),
                      16'($urandom_range(0, 50)), 16'($urandom_range(0, 400)),
                      8'($urandom_range(1, 255)));
    endtask

    task automatic advance_time();
        int unsigned span;
        span = 32'(gap_ms > delay_ms ? gap_ms : delay_ms) * 2 + 4;
        if ($urandom_range(99) < 8)
            now_ms = $urandom();
        else
            now_ms = now_ms + $urandom_range(0, span);
    endtask

    task automatic cursor_episode();
        logic [3:0] dirs;
        int         pick;
        dirs = 4'($urandom_range(1, 15));
        advance_time();
        push_word(OP_CUR_PRESS, dirs, now_ms);
        repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                advance_time();
                push_word(OP_TICK, 4'($urandom_range(15)), now_ms);
            end else if (pick < 70) begin
                push_word(OP_SEND, 4'($urandom_range(15)), now_ms);
            end else if (pick < 80) begin
                push_word(3'($urandom_range(OP_BTN_PRESS, OP_BTN_RELEASE)),
                          4'($urandom_range(15)), now_ms);
            end else if (pick < 88) begin
                advance_time();
                push_word(OP_CUR_PRESS, 4'($urandom_range(15)), now_ms);
            end else if (pick < 93) begin
                advance_time();
                push_word(OP_CUR_RELEASE, 4'($urandom_range(15)), now_ms);
            end else begin
                push_word(3'($urandom_range(7)), 4'($urandom_range(15)), $urandom());
            end
        end
        if ($urandom_range(3) != 0)
            push_word(OP_CUR_RELEASE, $urandom_range(3) == 0 ? 4'($urandom_range(15)) : MASK_ALL,
                      now_ms);
        push_word(OP_SEND, 4'($urandom_range(15)), now_ms);
    endtask

    task automatic run_phase(input int words);
        while (phase_words < words)
            cursor_episode();
    endtask

    // toggle buttons and send, with the report side held off at the start
    task automatic button_burst();
        logic [3:0] k;
        holdoff_req = 1'b1;
        repeat (12) begin
            k = 4'($urandom_range(7));
            push_word(OP_BTN_PRESS, k, now_ms);
            push_word(OP_SEND, 4'($urandom_range(15)), now_ms);
            push_word(OP_BTN_RELEASE, k, now_ms);
            push_word(OP_SEND, 4'($urandom_range(15)), now_ms);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_word(OP_BTN_PRESS, 4'd0, 32'd0);
        push_word(OP_BTN_PRESS, 4'd7, 32'd0);
        push_word(OP_BTN_PRESS, 4'd8, 32'd0);
        push_word(OP_BTN_PRESS, 4'd15, 32'd0);
        push_word(OP_SEND, 4'd0, 32'd0);
        push_word(OP_SEND, 4'd15, 32'd0);
        push_word(OP_BTN_RELEASE, 4'd15, 32'd0);
        push_word(OP_BTN_RELEASE, 4'd7, 32'd0);
        push_word(OP_CUR_PRESS, MASK_UP | MASK_LEFT, 32'd1000);
        push_word(OP_SEND, 4'd0, 32'd1000);
        push_word(OP_CUR_PRESS, MASK_ALL, 32'd1000);
        push_word(OP_TICK, 4'd0, 32'd1300);
        push_word(OP_TICK, 4'd0, 32'd1301);
        push_word(OP_TICK, 4'd0, 32'd1321);
        push_word(OP_TICK, 4'd0, 32'd1322);
        push_word(OP_SEND, 4'd0, 32'd1322);
        push_word(OP_CUR_RELEASE, MASK_RIGHT | MASK_DOWN, 32'd1330);
        push_word(OP_CUR_RELEASE, MASK_ALL, 32'd1340);
        push_word(OP_CUR_PRESS, MASK_RIGHT, 32'hFFFF_FFF0);
        push_word(OP_TICK, 4'd0, 32'h0000_0120);
        push_word(OP_SEND, 4'd0, 32'h0000_0120);
        push_word(OP_SPARE_6, 4'd15, 32'hFFFF_FFFF);
        push_word(OP_SPARE_7, 4'd15, 32'hFFFF_FFFF);
        push_word(OP_CUR_RELEASE, MASK_ALL, 32'h0000_0200);
        push_word(OP_SEND, 4'd0, 32'h0000_0200);

        load_settings(7'd127, 7'd127, 8'd255, 15'd32767, 16'd0, 16'd0, 8'd255);
        run_phase(PHASE_WORDS);
        load_settings(7'd1, 7'd1, 8'd1, 15'd1, 16'd65535, 16'd65535, 8'd1);
        run_phase(PHASE_WORDS);
        load_settings(7'd0, 7'd64, 8'd0, 15'd0, 16'd5, 16'd10, 8'd3);
        run_phase(PHASE_WORDS);
        load_random_settings();
        button_burst();
        run_phase(PHASE_WORDS);
        load_random_settings();
        run_phase(PHASE_WORDS / 2);
        drain();
        run_phase(PHASE_WORDS);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        load_settings(RST_MOVE_DELTA, RST_MAX_SPEED, RST_RAMP_REPEATS, RST_MOVE_CAP,
                      RST_REPEAT_INTERVAL, RST_INITIAL_DELAY, RST_REPEAT_CEILING);
        run_phase(PHASE_WORDS);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        load_random_settings();
        run_phase(PHASE_WORDS);

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("mouse_keys_accelerator verification clean");
        else
            $display("mouse_keys_accelerator verification failed");
        $finish;
    end

endmodule

`default_nettype wire
